[sv/b64d_pkg.sv]
// shared types, result codes and the symbol decode table for the base64 decoder
package b64d_pkg;

  localparam logic [7:0] SYM_SKIP = 8'd255;
  localparam logic [7:0] SYM_PAD  = 8'd254;
  localparam int         MAX_RESULTS = 4;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [23:0] count;
  } result_t;

  // all results caused by one input character, slot 0 first
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [1:0]                last;
  } bundle_t;

  function automatic logic [7:0] sym_value(input logic [7:0] ch);
    logic [7:0] v;
    v = SYM_SKIP;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      v = ch - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      v = ch - 8'h61 + 8'd26;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = ch - 8'h30 + 8'd52;
    end else if (ch == 8'h2b) begin
      v = 8'd62;
    end else if (ch == 8'h2f) begin
      v = 8'd63;
    end else if (ch == 8'h3d) begin
      v = SYM_PAD;
    end
    return v;
  endfunction

endpackage

[sv/b64d_ifs.sv]
// valid/ready channel interfaces for characters in and decoded results out
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       message_start;
  logic       message_end;

  modport source(output valid, output symbol, output message_start, output message_end,
                 input ready);
  modport sink(input valid, input symbol, input message_start, input message_end,
               output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [23:0] byte_count;
  logic        last_of_run;

  modport source(output valid, output kind, output out_byte, output byte_count,
                 output last_of_run, input ready);
  modport sink(input valid, input kind, input out_byte, input byte_count,
               input last_of_run, output ready);
endinterface

[sv/base64_decoder.sv]
// top level of the streaming base64 decoder
// Streaming Base64 decoder (A-Z a-z 0-9 + / alphabet). One character is taken per beat
// on chars; characters outside the alphabet are dropped, '=' decodes as zero and lowers
// a per-message pad budget that starts at three. Every fourth symbol yields one to three
// decoded bytes, or one overflow result when the group would pass the capacity, after
// which the message is ignored until message_start. message_end adds a done result with
// the byte count. Each character waits in the input register until its results are
// loaded into a bundle register, which hands them out one per cycle while results.ready
// is high; a character that makes no result leaves the input register without waiting.
// The bundle register draining its results sets the pace. The capacity register may only
// be written while no character is in flight.
module base64_decoder #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  b64d_in_if.sink     chars,
  b64d_out_if.source  results
);
  import b64d_pkg::*;

  bundle_t bundle;
  logic    bundle_valid;
  logic    take;

  b64d_unit #(.COUNT_BITS(COUNT_BITS)) u_unit (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .chars        (chars),
    .take         (take),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  b64d_serial u_serial (
    .clk     (clk),
    .rst     (rst),
    .load    (bundle_valid),
    .bundle  (bundle),
    .take    (take),
    .results (results)
  );

endmodule

[sv/b64d_unit.sv]
// input register, decoder state and the per-character step that builds a result bundle
module b64d_unit #(
  parameter int COUNT_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [23:0]        cfg_wr_data,
  b64d_in_if.sink            chars,
  input  logic               take,
  output logic               bundle_valid,
  output b64d_pkg::bundle_t  bundle
);
  import b64d_pkg::*;

  localparam int CW = ((COUNT_BITS > 24) ? COUNT_BITS : 24) + 1;

  // input register
  logic       in_v;
  logic [7:0] in_sym;
  logic       in_start;
  logic       in_end;

  // decoder state
  logic [23:0]           acc;
  logic [1:0]            sym_cnt;
  logic [1:0]            pad_budget;
  logic [COUNT_BITS-1:0] written;
  logic                  failed;
  logic [23:0]           capacity;

  logic [23:0]           acc0, acc1, acc_next;
  logic [1:0]            cnt0, cnt_next;
  logic [1:0]            pb0, pb1, pb_next;
  logic [COUNT_BITS-1:0] wc0, wc_next;
  logic                  fl0, fl_next;
  logic [7:0]            v;
  logic                  is_sym, is_pad, group, ovf;
  logic [1:0]            n_bytes;
  logic [2:0]            n_total;
  logic                  advance;

  always_comb begin
    acc0 = in_start ? 24'd0 : acc;
    cnt0 = in_start ? 2'd0 : sym_cnt;
    pb0  = in_start ? 2'd3 : pad_budget;
    wc0  = in_start ? '0 : written;
    fl0  = in_start ? 1'b0 : failed;

    v      = sym_value(in_sym);
    is_sym = !fl0 && (v != SYM_SKIP);
    is_pad = (v == SYM_PAD);
    pb1    = (is_pad && pb0 != 2'd0) ? pb0 - 2'd1 : pb0;
    acc1   = {acc0[17:0], (is_pad ? 6'd0 : v[5:0])};
    group  = is_sym && (cnt0 == 2'd3);
    ovf    = (CW'(wc0) + CW'(pb1)) > CW'(capacity);

    n_bytes = 2'd1 + 2'(pb1 > 2'd1) + 2'(pb1 > 2'd2);

    acc_next = acc0;
    cnt_next = cnt0;
    pb_next  = pb0;
    wc_next  = wc0;
    fl_next  = fl0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      bundle.res[i] = '{kind: KIND_BYTE, data: 8'd0, count: 24'd0};
    end
    n_total = 3'd0;

    if (is_sym) begin
      pb_next  = pb1;
      acc_next = group ? 24'd0 : acc1;
      cnt_next = group ? 2'd0 : cnt0 + 2'd1;
    end
    if (group) begin
      if (ovf) begin
        fl_next = 1'b1;
        bundle.res[0] = '{kind: KIND_OVERFLOW, data: 8'd0, count: 24'(wc0)};
        n_total = 3'd1;
      end else begin
        bundle.res[0] = '{kind: KIND_BYTE, data: acc1[23:16],
                          count: 24'(COUNT_BITS'(wc0 + COUNT_BITS'(1)))};
        bundle.res[1] = '{kind: KIND_BYTE, data: acc1[15:8],
                          count: 24'(COUNT_BITS'(wc0 + COUNT_BITS'(2)))};
        bundle.res[2] = '{kind: KIND_BYTE, data: acc1[7:0],
                          count: 24'(COUNT_BITS'(wc0 + COUNT_BITS'(3)))};
        wc_next = COUNT_BITS'(wc0 + COUNT_BITS'(n_bytes));
        n_total = 3'(n_bytes);
      end
    end
    if (in_end) begin
      bundle.res[n_total[1:0]] = '{kind: KIND_DONE, data: 8'd0, count: 24'(wc_next)};
      n_total = n_total + 3'd1;
    end
    bundle.last = 2'(n_total - 3'd1);
  end

  // an item with no results never waits on the output side
  assign advance      = in_v && (take || n_total == 3'd0);
  assign bundle_valid = advance && (n_total != 3'd0);
  assign chars.ready  = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v       <= 1'b0;
      acc        <= 24'd0;
      sym_cnt    <= 2'd0;
      pad_budget <= 2'd3;
      written    <= '0;
      failed     <= 1'b0;
      capacity   <= 24'hffffff;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (chars.valid && chars.ready) begin
        in_v <= 1'b1;
      end else if (advance) begin
        in_v <= 1'b0;
      end
      if (advance) begin
        acc        <= acc_next;
        sym_cnt    <= cnt_next;
        pad_budget <= pb_next;
        written    <= wc_next;
        failed     <= fl_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_sym   <= chars.symbol;
      in_start <= chars.message_start;
      in_end   <= chars.message_end;
    end
  end

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && in_end |-> bundle_valid)
    else $error("message end produced no done result");

  a_failed_holds: assert property (@(posedge clk) disable iff (rst)
    failed && !(advance && in_start) |=> failed)
    else $error("failure cleared without a message start");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    in_v && !advance |=> in_v && $stable(in_sym) && $stable(in_end))
    else $error("stalled input item lost or changed");

endmodule

[sv/b64d_serial.sv]
// result bundle register that hands out one result per output beat
module b64d_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  b64d_pkg::bundle_t bundle,
  output logic              take,
  b64d_out_if.source        results
);
  import b64d_pkg::*;

  logic    busy;
  logic [1:0] rd;
  logic [1:0] last;
  result_t [MAX_RESULTS-1:0] slots;
  result_t cur;
  logic    final_beat;

  assign cur        = slots[rd];
  assign final_beat = results.valid && results.ready && (rd == last);
  assign take       = !busy || final_beat;

  assign results.valid       = busy;
  assign results.kind        = cur.kind;
  assign results.out_byte    = cur.data;
  assign results.byte_count  = cur.count;
  assign results.last_of_run = (rd == last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rd   <= 2'd0;
      last <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      rd   <= 2'd0;
      last <= bundle.last;
    end else if (results.valid && results.ready) begin
      if (rd == last) begin
        busy <= 1'b0;
      end else begin
        rd <= rd + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= bundle.res;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> take)
    else $error("bundle loaded over undelivered results");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> rd <= last)
    else $error("read slot beyond last result");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    busy && cur.kind == KIND_DONE |-> rd == last)
    else $error("done result not final in its run");

endmodule

[verif/tb_base64_decoder.sv]
`timescale 1ns / 100ps
// testbench for base64_decoder: directed table and random messages checked against a predictor
module tb_base64_decoder;
  import b64d_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [23:0] count;
    logic        last;
  } dec_result_t;

  typedef struct {
    logic [7:0] ch;
    bit         st;
    bit         en;
  } char_beat_t;

  typedef enum {ROW_CHAR, ROW_CAP} row_op_t;

  typedef struct {
    row_op_t     op;
    logic [7:0]  ch;
    bit          st;
    bit          en;
    bit          typed;
    dec_result_t want;
    logic [23:0] value;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [23:0] cfg_wr_data;

  b64d_in_if  chars_if ();
  b64d_out_if results_if ();

  base64_decoder #(.COUNT_BITS(24)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .chars       (chars_if),
    .results     (results_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [23:0] acc_m;
  logic [1:0]  grp_pos;
  logic [1:0]  pads_left;
  logic [23:0] written_m;
  bit          failed_m;
  logic [23:0] capacity_m;

  dec_result_t decoded_q[$];
  dec_result_t step_q[$];
  dec_result_t oldest;
  row_t        plan[$];

  int  mismatches = 0;
  int  chars_accepted = 0;
  int  chars_counted = 0;
  int  results_checked = 0;
  int  bytes_seen = 0;
  int  dones_seen = 0;
  int  overflows_seen = 0;
  int  cap_writes = 0;
  int  idle_cycles = 0;
  int  src_gap_pct = 20;
  bit  quiet = 1'b0;
  bit  hold_pending = 1'b0;

  function automatic logic [7:0] alphabet_value(logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return ch - "A";
    if (ch >= "a" && ch <= "z") return ch - "a" + 8'd26;
    if (ch >= "0" && ch <= "9") return ch - "0" + 8'd52;
    if (ch == "+") return 8'd62;
    if (ch == "/") return 8'd63;
    if (ch == "=") return SYM_PAD;
    return SYM_SKIP;
  endfunction

  function automatic logic [7:0] value_char(logic [7:0] v);
    if (v < 26) return "A" + v;
    if (v < 52) return "a" + v - 8'd26;
    if (v < 62) return "0" + v - 8'd52;
    if (v == 62) return "+";
    return "/";
  endfunction

  function automatic void clear_message_model();
    acc_m     = '0;
    grp_pos   = '0;
    pads_left = 2'd3;
    written_m = '0;
    failed_m  = 1'b0;
  endfunction

  function automatic void add_result(kind_t k, logic [7:0] d);
    dec_result_t r;
    r = '{k, d, written_m, 1'b0};
    step_q.push_back(r);
  endfunction

  // advances the predictor by one character, results land in step_q
  function automatic void decode_char(logic [7:0] ch, bit st, bit en);
    logic [7:0]  v;
    logic [24:0] need;
    step_q.delete();
    if (st) clear_message_model();
    if (!failed_m) begin
      v = alphabet_value(ch);
      if (v != SYM_SKIP) begin
        if (v == SYM_PAD) begin
          v = 8'd0;
          if (pads_left != 0) pads_left = pads_left - 2'd1;
        end
        acc_m = {acc_m[17:0], v[5:0]};
        if (grp_pos == 2'd3) begin
          grp_pos = 2'd0;
          need = {1'b0, written_m} + 25'(pads_left);
          if (need > {1'b0, capacity_m}) begin
            failed_m = 1'b1;
            add_result(KIND_OVERFLOW, 8'd0);
          end else begin
            written_m = written_m + 24'd1;
            add_result(KIND_BYTE, acc_m[23:16]);
            if (pads_left > 1) begin
              written_m = written_m + 24'd1;
              add_result(KIND_BYTE, acc_m[15:8]);
            end
            if (pads_left > 2) begin
              written_m = written_m + 24'd1;
              add_result(KIND_BYTE, acc_m[7:0]);
            end
          end
          acc_m = '0;
        end else begin
          grp_pos = grp_pos + 2'd1;
        end
      end
    end
    if (en) add_result(KIND_DONE, 8'd0);
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
  endfunction

  function automatic void add_char(logic [7:0] ch, bit st = 1'b0, bit en = 1'b0);
    row_t r;
    r.op = ROW_CHAR;
    r.ch = ch;
    r.st = st;
    r.en = en;
    r.typed = 1'b0;
    r.want = '{KIND_BYTE, 8'd0, 24'd0, 1'b0};
    r.value = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_typed(logic [7:0] ch, bit st, bit en, kind_t k, logic [23:0] cnt);
    add_char(ch, st, en);
    plan[plan.size()-1].typed = 1'b1;
    plan[plan.size()-1].want = '{k, 8'd0, cnt, 1'b1};
  endfunction

  function automatic void add_cap(logic [23:0] v);
    add_char(8'd0);
    plan[plan.size()-1].op = ROW_CAP;
    plan[plan.size()-1].value = v;
  endfunction

  function automatic void check_field(string what, logic [23:0] want_v, logic [23:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
    end
  endfunction

  task automatic push_char(logic [7:0] ch, bit st, bit en, bit typed, dec_result_t want);
    if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
      chars_if.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    chars_if.valid         = 1'b1;
    chars_if.symbol        = ch;
    chars_if.message_start = st;
    chars_if.message_end   = en;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    decode_char(ch, st, en);
    if (typed) decoded_q.push_back(want);
    else foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    chars_accepted++;
    if (alphabet_value(ch) != SYM_SKIP || st || en) chars_counted++;
    @(negedge clk);
  endtask

  // only while idle: every result in, then room for a character that makes none
  task automatic write_capacity(logic [23:0] v);
    chars_if.valid = 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    capacity_m  = v;
    cap_writes++;
  endtask

  task automatic send_message();
    char_beat_t  beats[$];
    char_beat_t  b;
    dec_result_t none;
    int          shape;
    int          groups;
    int          npad;
    none = '{KIND_BYTE, 8'd0, 24'd0, 1'b0};
    shape = $urandom_range(0, 9);
    if (shape <= 7) begin
      groups = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
      npad = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      for (int g = 0; g < groups; g++) begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            b = '{8'($urandom_range(0, 255)), 1'b0, 1'b0};
            beats.push_back(b);
          end
          b.st = 1'b0;
          b.en = 1'b0;
          if (g == groups - 1 && k >= 4 - npad) b.ch = "=";
          else b.ch = value_char(8'($urandom_range(0, 63)));
          beats.push_back(b);
        end
      end
      beats[0].st = 1'b1;
      beats[beats.size()-1].en = 1'b1;
      // broken message: lost start mark, lost character or lost end mark
      if (shape == 7) begin
        case ($urandom_range(0, 2))
          0: beats[0].st = 1'b0;
          1: beats.delete($urandom_range(0, beats.size() - 1));
          default: beats[beats.size()-1].en = 1'b0;
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        b.ch = 8'($urandom_range(0, 255));
        b.st = ($urandom_range(0, 3) == 0);
        b.en = ($urandom_range(0, 3) == 0);
        beats.push_back(b);
      end
    end
    foreach (beats[i]) push_char(beats[i].ch, beats[i].st, beats[i].en, 1'b0, none);
  endtask

  task automatic random_phase(logic [23:0] cap, int n, int gap_pct, bit park);
    int target;
    write_capacity(cap);
    src_gap_pct = gap_pct;
    if (park) hold_pending = 1'b1;
    target = chars_counted + n;
    while (chars_counted < target) send_message();
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    results_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_pending) begin
        results_if.ready = 1'b0;
        repeat (90) @(negedge clk);
        hold_pending = 1'b0;
      end else if (quiet) begin
        results_if.ready = 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        results_if.ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        results_if.ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      results_checked++;
      case (results_if.kind)
        KIND_BYTE: bytes_seen++;
        KIND_DONE: dones_seen++;
        default: overflows_seen++;
      endcase
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result expected none actual kind %0d byte %0h count %0d last %0b",
                 $time, results_if.kind, results_if.out_byte, results_if.byte_count,
                 results_if.last_of_run);
      end else begin
        oldest = decoded_q.pop_front();
        check_field("kind", 24'(oldest.kind), 24'(results_if.kind));
        check_field("out_byte", 24'(oldest.data), 24'(results_if.out_byte));
        check_field("byte_count", oldest.count, results_if.byte_count);
        check_field("last_of_run", 24'(oldest.last), 24'(results_if.last_of_run));
      end
    end
  end

  // ends the run when neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= 2000) begin
        $display("%0t: no beat moved for %0d cycles, %0d results still owed",
                 $time, idle_cycles, decoded_q.size());
        $display("base64_decoder: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    chars_if.valid         = 1'b0;
    chars_if.symbol        = '0;
    chars_if.message_start = 1'b0;
    chars_if.message_end   = 1'b0;
    clear_message_model();
    capacity_m = 24'hFFFFFF;

    // capacity at its reset value
    add_typed(8'h00, 1'b1, 1'b1, KIND_DONE, 24'd0);
    add_char("T", 1'b1);
    add_char("W");
    add_char("F");
    add_char("u");
    // no start mark, stray byte before the group, top two symbol values
    add_char(8'hFF);
    add_char("/");
    add_char("+");
    add_char("9");
    add_char("z");
    add_char("A");
    add_char("A");
    add_char("=");
    add_char("=");
    // pad budget runs dry, group still gives one byte
    add_char("=");
    add_char("=");
    add_char("=");
    add_char("=", 1'b0, 1'b1);
    // zero capacity: first group overflows, rest of message ignored
    add_cap(24'd0);
    add_char("Q", 1'b1);
    add_char("U");
    add_char("J");
    add_typed("D", 1'b0, 1'b0, KIND_OVERFLOW, 24'd0);
    add_char("R");
    add_typed("=", 1'b0, 1'b1, KIND_DONE, 24'd0);

    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CAP) write_capacity(plan[i].value);
      else push_char(plan[i].ch, plan[i].st, plan[i].en, plan[i].typed, plan[i].want);
    end

    random_phase(24'hFFFFFF, 20, 20, 1'b0);
    random_phase(24'd5, 20, 5, 1'b1);
    random_phase(24'd0, 15, 30, 1'b0);
    random_phase(24'($urandom_range(6, 30)), 20, 20, 1'b0);
    random_phase(24'd9, 15, 0, 1'b0);
    quiet = 1'b1;
    random_phase(24'hFFFFFF, 20, 0, 1'b0);
    chars_if.valid = 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d characters in, %0d results checked (%0d bytes, %0d done, %0d overflow)",
             chars_accepted, results_checked, bytes_seen, dones_seen, overflows_seen);
    $display("%0d capacity writes, zero and full scale included, one long output hold-off",
             cap_writes);
    if (mismatches == 0) begin
      $display("base64_decoder: match");
    end else begin
      $display("base64_decoder: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
sv/b64d_pkg.sv
sv/b64d_ifs.sv
sv/b64d_unit.sv
sv/b64d_serial.sv
sv/base64_decoder.sv
verif/tb_base64_decoder.sv
